>>> design/rcs_pkg.sv
package rcs_pkg;

  // Channel geometry.
  localparam int COLOR_BITS = 8;
  localparam int NUM_CHAN   = 4;
  localparam logic [COLOR_BITS-1:0] CHAN_FULL = {COLOR_BITS{1'b1}};

  // Channel positions inside a pixel vector.
  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;
  localparam int CH_ALPHA = 3;

  // Request codes.
  localparam logic REQ_MEASURE = 1'b0;
  localparam logic REQ_STRETCH = 1'b1;

  // Depth of the job queue between the front and back parts.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Divider step counter.
  localparam int STEP_W = (COLOR_BITS > 1) ? $clog2(COLOR_BITS) : 1;
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(COLOR_BITS - 1);

  typedef logic [NUM_CHAN-1:0][COLOR_BITS-1:0]   pix_t;
  typedef logic [NUM_CHAN-1:0][2*COLOR_BITS-1:0] wide_t;

  // One stretch job: per channel, dividend and divisor of the final quotient.
  typedef struct packed {
    wide_t num;
    pix_t  span;
  } job_t;

endpackage

>>> design/rgba_contrast_stretch.sv
// Min/max contrast stretch for RGBA pixels. Stream the image twice: measure
// transactions (in_req_type 0) fold each pixel into a per-channel minimum and
// maximum, with in_restart clearing the range first; stretch transactions
// (in_req_type 1) produce one result of (p - min) * 255 / (max - min), floored,
// per channel, 0 for an empty range and saturated outside it. Measure
// transactions are taken one per cycle while the job queue has room. Each
// stretch transaction then passes through the back part's four-lane
// radix-2 restoring divider, which sets the sustained stretch rate; a
// two-entry job queue lets the front keep accepting while it works, and full
// rises only when both entries of that queue hold jobs. The range is captured
// when the stretch transaction is accepted. has_alpha is written through
// cfg_valid, which is always ready; with it low the alpha channel reads as zero.
module rgba_contrast_stretch
  import rcs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  output logic                  full,
  input  logic                  in_req_type,
  input  logic                  in_restart,
  input  logic [COLOR_BITS-1:0] in_red,
  input  logic [COLOR_BITS-1:0] in_green,
  input  logic [COLOR_BITS-1:0] in_blue,
  input  logic [COLOR_BITS-1:0] in_alpha,
  output logic                  empty,
  input  logic                  pop,
  output logic [COLOR_BITS-1:0] out_red,
  output logic [COLOR_BITS-1:0] out_green,
  output logic [COLOR_BITS-1:0] out_blue,
  output logic [COLOR_BITS-1:0] out_alpha,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_data
);

  pix_t in_pix;
  pix_t out_pix;
  logic q_push, q_pop, q_full, q_empty;
  job_t q_wdata, q_rdata;

  assign cfg_ready = 1'b1;

  // Pack and unpack the channel ports.
  always_comb begin
    in_pix[CH_RED]   = in_red;
    in_pix[CH_GREEN] = in_green;
    in_pix[CH_BLUE]  = in_blue;
    in_pix[CH_ALPHA] = in_alpha;
  end

  assign out_red   = out_pix[CH_RED];
  assign out_green = out_pix[CH_GREEN];
  assign out_blue  = out_pix[CH_BLUE];
  assign out_alpha = out_pix[CH_ALPHA];

  rcs_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .in_req_type (in_req_type),
    .in_restart  (in_restart),
    .in_pix      (in_pix),
    .cfg_valid   (cfg_valid && cfg_ready),
    .cfg_data    (cfg_data),
    .q_full      (q_full),
    .full        (full),
    .q_push      (q_push),
    .q_job       (q_wdata)
  );

  rcs_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .q_wdata (q_wdata),
    .q_pop   (q_pop),
    .q_full  (q_full),
    .q_empty (q_empty),
    .q_rdata (q_rdata)
  );

  rcs_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_rdata (q_rdata),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .out_pix (out_pix)
  );

endmodule

>>> design/rcs_front.sv
module rcs_front
  import rcs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  logic                  in_req_type,
  input  logic                  in_restart,
  input  pix_t                  in_pix,
  input  logic                  cfg_valid,
  input  logic                  cfg_data,
  input  logic                  q_full,
  output logic                  full,
  output logic                  q_push,
  output job_t                  q_job
);

  logic has_alpha_r;
  pix_t min_r, min_nxt;
  pix_t max_r, max_nxt;
  pix_t pix;
  pix_t base_min, base_max;
  logic accept;
  logic meas_acc;

  // Stalls only when the job queue has no room.
  assign full     = q_full;
  assign accept   = push && !q_full;
  assign meas_acc = accept && (in_req_type == REQ_MEASURE);
  assign q_push   = accept && (in_req_type == REQ_STRETCH);

  // Alpha reads as zero when the image carries none.
  always_comb begin
    pix = in_pix;
    if (!has_alpha_r) begin
      pix[CH_ALPHA] = '0;
    end
  end

  // Running range update for measure transactions.
  always_comb begin
    min_nxt = min_r;
    max_nxt = max_r;
    for (int c = 0; c < NUM_CHAN; c++) begin
      base_min[c] = in_restart ? CHAN_FULL : min_r[c];
      base_max[c] = in_restart ? '0 : max_r[c];
      min_nxt[c]  = (pix[c] < base_min[c]) ? pix[c] : base_min[c];
      max_nxt[c]  = (pix[c] > base_max[c]) ? pix[c] : base_max[c];
    end
  end

  // Dividend and divisor for a stretch transaction. Saturated and empty
  // ranges become a division by one so the back part needs no special case.
  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      if ((max_r[c] <= min_r[c]) || (pix[c] <= min_r[c])) begin
        q_job.num[c]  = '0;
        q_job.span[c] = COLOR_BITS'(1);
      end else if (pix[c] >= max_r[c]) begin
        q_job.num[c]  = (2*COLOR_BITS)'(CHAN_FULL);
        q_job.span[c] = COLOR_BITS'(1);
      end else begin
        // (p - min) * FULL written as a shift and a subtract.
        q_job.num[c]  = {COLOR_BITS'(pix[c] - min_r[c]), {COLOR_BITS{1'b0}}}
                      - (2*COLOR_BITS)'(pix[c] - min_r[c]);
        q_job.span[c] = max_r[c] - min_r[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      has_alpha_r <= 1'b1;
      for (int c = 0; c < NUM_CHAN; c++) begin
        min_r[c] <= CHAN_FULL;
        max_r[c] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        has_alpha_r <= cfg_data;
      end
      if (meas_acc) begin
        min_r <= min_nxt;
        max_r <= max_nxt;
      end
    end
  end

  // After any measured pixel every channel holds a proper range.
  a_range_order: assert property (@(posedge clk) disable iff (!rst_n)
    meas_acc |=> (min_r[0] <= max_r[0]) && (min_r[1] <= max_r[1]) &&
                 (min_r[2] <= max_r[2]) && (min_r[3] <= max_r[3]))
    else $error("range inverted after a measure transaction");

endmodule

>>> design/rcs_queue.sv
module rcs_queue
  import rcs_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic q_push,
  input  job_t q_wdata,
  input  logic q_pop,
  output logic q_full,
  output logic q_empty,
  output job_t q_rdata
);

  job_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push, do_pop;

  assign q_full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign q_empty = (cnt_r == '0);
  assign do_push = q_push && !q_full;
  assign do_pop  = q_pop && !q_empty;
  assign q_rdata = mem_r[rd_ptr_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= q_wdata;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // The fill count never passes the depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("job queue overfilled");

endmodule

>>> design/rcs_back.sv
module rcs_back
  import rcs_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic q_empty,
  input  job_t q_rdata,
  output logic q_pop,
  input  logic pop,
  output logic empty,
  output pix_t out_pix
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [STEP_W-1:0] step_r;
  pix_t              rem_r, rem_nxt;
  pix_t              low_r, low_nxt;
  pix_t              span_r;
  pix_t              res_r;
  logic              out_valid_r;
  logic              take;
  logic              load_out;
  pix_t              load_val;
  logic [NUM_CHAN-1:0][COLOR_BITS:0] trial;
  logic [NUM_CHAN-1:0]               ge;

  assign empty   = !out_valid_r;
  assign out_pix = res_r;
  assign take    = !out_valid_r || pop;
  assign q_pop   = (state_r == ST_IDLE) && !q_empty;

  // One restoring division step in each of the four lanes.
  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      trial[c]   = {rem_r[c], low_r[c][COLOR_BITS-1]};
      ge[c]      = (trial[c] >= {1'b0, span_r[c]});
      rem_nxt[c] = ge[c] ? COLOR_BITS'(trial[c] - {1'b0, span_r[c]})
                         : trial[c][COLOR_BITS-1:0];
      low_nxt[c] = {low_r[c][COLOR_BITS-2:0], ge[c]};
    end
  end

  // Sequencer: fetch a job, run the steps, hand the quotient to the output.
  always_comb begin
    state_nxt = state_r;
    load_out  = 1'b0;
    load_val  = low_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (step_r == STEP_LAST) begin
          load_val = low_nxt;
          if (take) begin
            load_out  = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (take) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Lane registers.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      for (int c = 0; c < NUM_CHAN; c++) begin
        rem_r[c] <= q_rdata.num[c][2*COLOR_BITS-1:COLOR_BITS];
        low_r[c] <= q_rdata.num[c][COLOR_BITS-1:0];
      end
      span_r <= q_rdata.span;
    end else if (state_r == ST_DIV) begin
      rem_r <= rem_nxt;
      low_r <= low_nxt;
    end
    if (load_out) begin
      res_r <= load_val;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (q_pop) begin
        step_r <= '0;
      end else if (state_r == ST_DIV) begin
        step_r <= step_r + 1'b1;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // A finished quotient only waits while the output register is occupied.
  a_hold_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HOLD) |-> out_valid_r)
    else $error("quotient held with output register free");

  // The partial remainder stays below the divisor in every lane.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r[0] < span_r[0]) && (rem_r[1] < span_r[1]) &&
                            (rem_r[2] < span_r[2]) && (rem_r[3] < span_r[3]))
    else $error("partial remainder out of range");

endmodule

>>> dv/tb_top.sv
module tb_top
  import rcs_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Cycles to let the divider and job queue settle once nothing is expected.
  localparam int SETTLE_CYCLES = 3 * (COLOR_BITS + 1) + 2 * QUEUE_DEPTH + 4;
  localparam int TARGET_ITEMS  = 1400;
  localparam int QUIET_ITEMS   = 1250;
  localparam int HOLD_CYCLES   = 300;
  localparam int HOLD_AFTER    = 120;

  // Scoreboard: keeps its own copy of the per-channel range and the alpha
  // setting, and queues one expected pixel per stretch transaction.
  class stretch_scoreboard;
    logic [COLOR_BITS-1:0] lo_seen [NUM_CHAN];
    logic [COLOR_BITS-1:0] hi_seen [NUM_CHAN];
    bit   alpha_on;
    pix_t expected_px [$];
    int   mismatches;
    int   n_measure;
    int   n_stretch;
    int   n_restart;
    int   n_flat;
    int   n_clipped;
    int   n_checked;

    function new();
      clear_range();
      alpha_on   = 1'b1;
      mismatches = 0;
    endfunction

    function void clear_range();
      for (int c = 0; c < NUM_CHAN; c++) begin
        lo_seen[c] = CHAN_FULL;
        hi_seen[c] = '0;
      end
    endfunction

    function void set_alpha(bit on);
      alpha_on = on;
    endfunction

    function int pending();
      return expected_px.size();
    endfunction

    // One channel of the stretch: exact floor of (p - lo) * FULL / (hi - lo).
    function logic [COLOR_BITS-1:0] stretch_value(logic [COLOR_BITS-1:0] p,
                                                  logic [COLOR_BITS-1:0] lo,
                                                  logic [COLOR_BITS-1:0] hi);
      logic [2*COLOR_BITS-1:0] num;
      logic [2*COLOR_BITS-1:0] span;
      if (hi <= lo) begin
        n_flat++;
        return '0;
      end
      if (p <= lo) begin
        if (p < lo) n_clipped++;
        return '0;
      end
      if (p >= hi) begin
        if (p > hi) n_clipped++;
        return CHAN_FULL;
      end
      num  = (2*COLOR_BITS)'(p - lo) * (2*COLOR_BITS)'(CHAN_FULL);
      span = (2*COLOR_BITS)'(hi - lo);
      return COLOR_BITS'(num / span);
    endfunction

    // Accepted input transaction: fold into the range or queue a result.
    function void note_input(logic req, logic clr, pix_t px);
      pix_t want;
      if (!alpha_on) px[CH_ALPHA] = '0;
      if (req == REQ_MEASURE) begin
        n_measure++;
        if (clr) begin
          clear_range();
          n_restart++;
        end
        for (int c = 0; c < NUM_CHAN; c++) begin
          if (px[c] < lo_seen[c]) lo_seen[c] = px[c];
          if (px[c] > hi_seen[c]) hi_seen[c] = px[c];
        end
      end else begin
        n_stretch++;
        for (int c = 0; c < NUM_CHAN; c++)
          want[c] = stretch_value(px[c], lo_seen[c], hi_seen[c]);
        expected_px.push_back(want);
      end
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("%0t mismatch: %s", $realtime, what);
    endtask

    // Accepted result transaction: compare every channel with the oldest entry.
    task check_result(pix_t got);
      pix_t want;
      string chan;
      if (expected_px.size() == 0) begin
        report_mismatch($sformatf("result %h with no stretch transaction pending", got));
        return;
      end
      want = expected_px.pop_front();
      n_checked++;
      for (int c = 0; c < NUM_CHAN; c++) begin
        case (c)
          CH_RED:   chan = "out_red";
          CH_GREEN: chan = "out_green";
          CH_BLUE:  chan = "out_blue";
          default:  chan = "out_alpha";
        endcase
        if (got[c] !== want[c])
          report_mismatch($sformatf("result %0d %s got %h want %h",
                                    n_checked, chan, got[c], want[c]));
      end
    endtask
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  push;
  logic                  full;
  logic                  in_req_type;
  logic                  in_restart;
  logic [COLOR_BITS-1:0] in_red;
  logic [COLOR_BITS-1:0] in_green;
  logic [COLOR_BITS-1:0] in_blue;
  logic [COLOR_BITS-1:0] in_alpha;
  logic                  empty;
  logic                  pop;
  logic [COLOR_BITS-1:0] out_red;
  logic [COLOR_BITS-1:0] out_green;
  logic [COLOR_BITS-1:0] out_blue;
  logic [COLOR_BITS-1:0] out_alpha;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic                  cfg_data;

  stretch_scoreboard sb = new();
  int items_sent  = 0;
  int n_results   = 0;
  int n_cfg       = 0;
  bit quiet       = 1'b0;
  bit held_off    = 1'b0;
  int full_cycles = 0;

  rgba_contrast_stretch DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .full        (full),
    .in_req_type (in_req_type),
    .in_restart  (in_restart),
    .in_red      (in_red),
    .in_green    (in_green),
    .in_blue     (in_blue),
    .in_alpha    (in_alpha),
    .empty       (empty),
    .pop         (pop),
    .out_red     (out_red),
    .out_green   (out_green),
    .out_blue    (out_blue),
    .out_alpha   (out_alpha),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  // Clock.
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Run limit, far above the slowest legal run.
  initial begin
    #2000000;
    $display("[rgba_contrast_stretch] ERROR");
    $finish;
  end

  // Result monitor: check every accepted result transaction.
  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      sb.check_result({out_alpha, out_blue, out_green, out_red});
      n_results++;
    end
    if (rst_n && push && full) full_cycles++;
  end

  // Receiver: random pop bursts, plus one long hold-off so the block backs up.
  initial begin
    pop = 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      if (!held_off && n_results >= HOLD_AFTER) begin
        held_off = 1'b1;
        pop = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        pop = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
      pop = 1'b1;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  end

  function automatic pix_t px(int r, int g, int b, int a);
    pix_t p;
    p[CH_RED]   = COLOR_BITS'(r);
    p[CH_GREEN] = COLOR_BITS'(g);
    p[CH_BLUE]  = COLOR_BITS'(b);
    p[CH_ALPHA] = COLOR_BITS'(a);
    return p;
  endfunction

  function automatic pix_t random_px();
    return pix_t'({$urandom, $urandom});
  endfunction

  // Send one input transaction; called and returns at a falling edge.
  task automatic send_pixel(input logic req, input logic clr, input pix_t p);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      push = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    push        = 1'b1;
    in_req_type = req;
    in_restart  = clr;
    in_red      = p[CH_RED];
    in_green    = p[CH_GREEN];
    in_blue     = p[CH_BLUE];
    in_alpha    = p[CH_ALPHA];
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_input(req, clr, p);
    items_sent++;
    @(negedge clk);
  endtask

  // Stop sending until every expected result is back and the block is quiet.
  task automatic wait_drained();
    push = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write has_alpha while the block is idle.
  task automatic write_alpha(input bit on);
    wait_drained();
    cfg_valid = 1'b1;
    cfg_data  = on;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_alpha(on);
    n_cfg++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // One random image: a measure pass over its pixels, then a stretch pass.
  task automatic send_image();
    pix_t img [$];
    pix_t p;
    int   n;
    int   lo [NUM_CHAN];
    int   span [NUM_CHAN];
    n = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
    for (int c = 0; c < NUM_CHAN; c++) begin
      case ($urandom_range(0, 3))
        0: begin lo[c] = $urandom_range(0, 255); span[c] = 0; end
        1: begin lo[c] = $urandom_range(0, 247); span[c] = $urandom_range(1, 8); end
        2: begin lo[c] = 0; span[c] = 255; end
        default: begin
          lo[c]   = $urandom_range(0, 255);
          span[c] = $urandom_range(0, 255 - lo[c]);
        end
      endcase
    end
    for (int i = 0; i < n; i++) begin
      for (int c = 0; c < NUM_CHAN; c++)
        p[c] = COLOR_BITS'(lo[c] + $urandom_range(0, span[c]));
      img.push_back(p);
    end
    // Measure pass; usually restarted, sometimes folded into the old range.
    for (int i = 0; i < n; i++)
      send_pixel(REQ_MEASURE, (i == 0) ? ($urandom_range(0, 7) != 0) :
                                         ($urandom_range(0, 31) == 0), img[i]);
    // Stretch pass in random order, with some pixels from outside the image.
    for (int i = 0; i < n; i++) begin
      p = ($urandom_range(0, 7) == 0) ? random_px() : img[$urandom_range(0, n - 1)];
      send_pixel(REQ_STRETCH, 1'($urandom_range(0, 1)), p);
    end
  endtask

  // Main sequence.
  initial begin
    rst_n       = 1'b0;
    push        = 1'b0;
    in_req_type = REQ_MEASURE;
    in_restart  = 1'b0;
    in_red      = '0;
    in_green    = '0;
    in_blue     = '0;
    in_alpha    = '0;
    cfg_valid   = 1'b0;
    cfg_data    = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Nothing measured since reset: every channel has an empty range.
    send_pixel(REQ_STRETCH, 1'b0, px(128, 0, 255, 77));
    // Full red range, flat green, equal blue and alpha ranges.
    send_pixel(REQ_MEASURE, 1'b1, px(0, 255, 10, 200));
    send_pixel(REQ_MEASURE, 1'b0, px(255, 255, 200, 10));
    // Below the minimum and above the maximum saturate.
    send_pixel(REQ_STRETCH, 1'b0, px(0, 255, 5, 250));
    send_pixel(REQ_STRETCH, 1'b0, px(255, 0, 200, 10));
    // A restart flag on a stretch transaction is ignored.
    send_pixel(REQ_STRETCH, 1'b1, px(128, 128, 105, 77));
    send_pixel(REQ_STRETCH, 1'b0, px(1, 254, 11, 199));
    // A single measured pixel gives a zero range everywhere.
    send_pixel(REQ_MEASURE, 1'b1, px(100, 100, 100, 100));
    send_pixel(REQ_STRETCH, 1'b0, px(100, 100, 100, 100));
    send_pixel(REQ_STRETCH, 1'b0, px(99, 101, 0, 255));

    // Alpha off: alpha reads as zero in both passes.
    write_alpha(1'b0);
    send_pixel(REQ_MEASURE, 1'b1, px(0, 0, 0, 255));
    send_pixel(REQ_MEASURE, 1'b0, px(255, 255, 255, 0));
    send_pixel(REQ_STRETCH, 1'b0, px(37, 200, 255, 255));
    send_pixel(REQ_STRETCH, 1'b0, px(170, 85, 1, 170));

    // Alpha back on, then a range that needs real division in every channel.
    write_alpha(1'b1);
    send_pixel(REQ_MEASURE, 1'b1, px(20, 30, 40, 50));
    send_pixel(REQ_MEASURE, 1'b0, px(220, 230, 240, 250));
    send_pixel(REQ_STRETCH, 1'b0, px(120, 131, 142, 153));
    send_pixel(REQ_STRETCH, 1'b0, px(170, 85, 219, 51));
    send_pixel(REQ_STRETCH, 1'b0, px(21, 229, 41, 249));

    // Random images, with noise transactions and occasional register writes.
    while (items_sent < TARGET_ITEMS) begin
      if (items_sent >= QUIET_ITEMS) quiet = 1'b1;
      if (!quiet && $urandom_range(0, 11) == 0) write_alpha(1'($urandom_range(0, 1)));
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 4))
          send_pixel(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), random_px());
      end
      send_image();
    end

    // Final drain, including the settle wait, to catch stray results.
    quiet = 1'b1;
    wait_drained();
    $display("Sent %0d transactions (%0d measure, %0d restarts, %0d stretch), %0d has_alpha writes.",
             items_sent, sb.n_measure, sb.n_restart, sb.n_stretch, n_cfg);
    $display("Checked %0d results: %0d flat-range channels, %0d clipped, %0d cycles stalled by full.",
             sb.n_checked, sb.n_flat, sb.n_clipped, full_cycles);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[rgba_contrast_stretch] OK");
    end else begin
      $display("[rgba_contrast_stretch] ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
design/rcs_pkg.sv
design/rcs_front.sv
design/rcs_queue.sv
design/rcs_back.sv
design/rgba_contrast_stretch.sv
dv/tb_top.sv
